[hw/rtl/mdpm_pkg.sv]
// Package with types, constants and helpers of the multi-deque pool manager.
package mdpm_pkg;

  localparam int NUM_QUEUES = 1024;
  localparam int POOL_DEPTH = 4096;
  localparam int VALUE_BITS = 32;

  localparam int QFIELD_W = 10;
  localparam int QRAM_W = $clog2(NUM_QUEUES);
  localparam int NODE_W = $clog2(POOL_DEPTH);
  localparam int PTR_W = NODE_W + 1;
  localparam int CLR_N = (POOL_DEPTH > NUM_QUEUES) ? POOL_DEPTH : NUM_QUEUES;
  localparam int CLR_W = $clog2(CLR_N);

  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_MERGE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STS_POPPED = 2'd0,
    STS_EMPTY  = 2'd1,
    STS_FULL   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_PU1,
    S_PU2,
    S_PO1,
    S_PO2,
    S_PO3,
    S_MG1,
    S_MG2,
    S_WALK,
    S_LK0,
    S_LK1,
    S_LK2
  } state_t;

  typedef struct packed {
    logic [1:0]          command;
    logic [QFIELD_W-1:0] queue_a;
    logic [QFIELD_W-1:0] queue_b;
    logic                at_back;
    logic signed [31:0]  push_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pop_value;
  } out_beat_t;

  typedef struct packed {
    ptr_t head;
    ptr_t tail;
  } qent_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    ptr_t                  next;
    ptr_t                  prev;
  } node_t;

  function automatic logic is_nil(input ptr_t p);
    return p == NIL;
  endfunction

  function automatic logic q_ok(input logic [QFIELD_W-1:0] q);
    return 32'(q) < NUM_QUEUES;
  endfunction

  function automatic logic signed [31:0] widen(input logic [VALUE_BITS-1:0] v);
    return 32'(signed'(v));
  endfunction

endpackage

[hw/rtl/mdpm_ram.sv]
// Simple dual-port synchronous RAM with one write port and a registered read port.
module mdpm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 26,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/multi_deque_pool_manager_unit.sv]
// Top level of the multi-deque pool manager: command sequencer around two RAMs.
//
// Commands enter on in_data with start; a beat is taken when start is high
// and busy is low. Push places a value at the front or back of a queue, pop
// removes one from either end, merge appends queue_b to queue_a (optionally
// reversed) and leaves queue_b empty. Queue heads and tails live in one RAM,
// the linked nodes (value, next, prev) in another, each with one write and
// one registered read port.
// A pop answers on out_data with a one-cycle out_valid strobe; so does a push
// that finds the pool full or names an out-of-range queue. Other commands give
// no result beat. A pop result is registered from the accepting cycle for an
// out-of-range queue, after the queue RAM read for an empty queue, and after
// the queue and node RAM reads for a popped value. A reversed merge walks the
// nodes of queue_b one by one, and each step of that list walk waits for one
// node RAM read.
// After reset the block runs a clearing pass over max(POOL_DEPTH, NUM_QUEUES)
// entries, 4096 here, that empties all queues and chains the free list; busy
// stays high meanwhile. The receiver cannot stall: each result beat is valid
// for exactly one cycle.
module multi_deque_pool_manager_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mdpm_pkg::in_beat_t  in_data,
  output logic               out_valid,
  output mdpm_pkg::out_beat_t out_data
);
  import mdpm_pkg::*;

  state_t    state_r, state_nxt;
  in_beat_t  in_r, in_nxt;
  ptr_t      nd_r, nd_nxt;
  ptr_t      nb_r, nb_nxt;
  ptr_t      h_r, h_nxt;
  ptr_t      t_r, t_nxt;
  ptr_t      hb_r, hb_nxt;
  ptr_t      tb_r, tb_nxt;
  ptr_t      free_head_r, free_head_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_r, out_nxt;

  logic              q_we, q_re;
  logic [QRAM_W-1:0] q_waddr, q_raddr;
  qent_t             q_wdata, q_rdata;
  logic              n_we, n_re;
  logic [NODE_W-1:0] n_waddr, n_raddr;
  node_t             n_wdata, n_rdata;

  ptr_t nn;

  mdpm_ram #(.DEPTH(NUM_QUEUES), .WIDTH($bits(qent_t))) u_qram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  mdpm_ram #(.DEPTH(POOL_DEPTH), .WIDTH($bits(node_t))) u_nram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .re    (n_re),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    nd_r  <= nd_nxt;
    nb_r  <= nb_nxt;
    h_r   <= h_nxt;
    t_r   <= t_nxt;
    hb_r  <= hb_nxt;
    tb_r  <= tb_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    nd_nxt        = nd_r;
    nb_nxt        = nb_r;
    h_nxt         = h_r;
    t_nxt         = t_r;
    hb_nxt        = hb_r;
    tb_nxt        = tb_r;
    free_head_nxt = free_head_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    q_we    = 1'b0;
    q_waddr = QRAM_W'(in_r.queue_a);
    q_wdata = '{head: NIL, tail: NIL};
    q_re    = 1'b0;
    q_raddr = QRAM_W'(in_r.queue_a);
    n_we    = 1'b0;
    n_waddr = NODE_W'(nd_r);
    n_wdata = n_rdata;
    n_re    = 1'b0;
    n_raddr = NODE_W'(nd_r);
    nn      = in_r.at_back ? n_rdata.prev : n_rdata.next;

    unique case (state_r)
      S_CLR: begin
        if (32'(clr_cnt_r) < POOL_DEPTH) begin
          n_we    = 1'b1;
          n_waddr = NODE_W'(clr_cnt_r);
          n_wdata = '{value: '0, next: PTR_W'(clr_cnt_r) + PTR_W'(1), prev: NIL};
        end
        if (32'(clr_cnt_r) < NUM_QUEUES) begin
          q_we    = 1'b1;
          q_waddr = QRAM_W'(clr_cnt_r);
        end
        clr_cnt_nxt = clr_cnt_r + CLR_W'(1);
        if (32'(clr_cnt_r) == CLR_N - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          in_nxt = in_data;
          unique case (in_data.command)
            CMD_PUSH: begin
              if (!q_ok(in_data.queue_a) || is_nil(free_head_r)) begin
                out_valid_nxt = 1'b1;
                out_nxt       = '{status: STS_FULL, pop_value: '0};
              end else begin
                q_re      = 1'b1;
                q_raddr   = QRAM_W'(in_data.queue_a);
                n_re      = 1'b1;
                n_raddr   = NODE_W'(free_head_r);
                nd_nxt    = free_head_r;
                state_nxt = S_PU1;
              end
            end
            CMD_POP: begin
              if (!q_ok(in_data.queue_a)) begin
                out_valid_nxt = 1'b1;
                out_nxt       = '{status: STS_EMPTY, pop_value: '0};
              end else begin
                q_re      = 1'b1;
                q_raddr   = QRAM_W'(in_data.queue_a);
                state_nxt = S_PO1;
              end
            end
            CMD_MERGE: begin
              if (q_ok(in_data.queue_a) && q_ok(in_data.queue_b) &&
                  in_data.queue_a != in_data.queue_b) begin
                q_re      = 1'b1;
                q_raddr   = QRAM_W'(in_data.queue_b);
                state_nxt = S_MG1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PU1: begin
        free_head_nxt = n_rdata.next;
        n_we          = 1'b1;
        n_waddr       = NODE_W'(nd_r);
        q_we          = 1'b1;
        if (in_r.at_back) begin
          n_wdata = '{value: VALUE_BITS'(in_r.push_value), next: NIL, prev: q_rdata.tail};
          q_wdata = '{head: is_nil(q_rdata.tail) ? nd_r : q_rdata.head, tail: nd_r};
          nb_nxt  = q_rdata.tail;
        end else begin
          n_wdata = '{value: VALUE_BITS'(in_r.push_value), next: q_rdata.head, prev: NIL};
          q_wdata = '{head: nd_r, tail: is_nil(q_rdata.head) ? nd_r : q_rdata.tail};
          nb_nxt  = q_rdata.head;
        end
        if (is_nil(nb_nxt)) begin
          state_nxt = S_IDLE;
        end else begin
          n_re      = 1'b1;
          n_raddr   = NODE_W'(nb_nxt);
          state_nxt = S_PU2;
        end
      end
      S_PU2: begin
        n_we    = 1'b1;
        n_waddr = NODE_W'(nb_r);
        n_wdata = n_rdata;
        if (in_r.at_back) begin
          n_wdata.next = nd_r;
        end else begin
          n_wdata.prev = nd_r;
        end
        state_nxt = S_IDLE;
      end
      S_PO1: begin
        if (is_nil(q_rdata.head)) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: STS_EMPTY, pop_value: '0};
          state_nxt     = S_IDLE;
        end else begin
          h_nxt     = q_rdata.head;
          t_nxt     = q_rdata.tail;
          nd_nxt    = in_r.at_back ? q_rdata.tail : q_rdata.head;
          n_re      = 1'b1;
          n_raddr   = NODE_W'(nd_nxt);
          state_nxt = S_PO2;
        end
      end
      S_PO2: begin
        q_we = 1'b1;
        if (in_r.at_back) begin
          q_wdata = '{head: is_nil(nn) ? NIL : h_r, tail: nn};
        end else begin
          q_wdata = '{head: nn, tail: is_nil(nn) ? NIL : t_r};
        end
        n_we          = 1'b1;
        n_waddr       = NODE_W'(nd_r);
        n_wdata       = n_rdata;
        n_wdata.next  = free_head_r;
        free_head_nxt = nd_r;
        out_valid_nxt = 1'b1;
        out_nxt       = '{status: STS_POPPED, pop_value: widen(n_rdata.value)};
        nb_nxt        = nn;
        if (is_nil(nn)) begin
          state_nxt = S_IDLE;
        end else begin
          n_re      = 1'b1;
          n_raddr   = NODE_W'(nn);
          state_nxt = S_PO3;
        end
      end
      S_PO3: begin
        n_we    = 1'b1;
        n_waddr = NODE_W'(nb_r);
        n_wdata = n_rdata;
        if (in_r.at_back) begin
          n_wdata.next = NIL;
        end else begin
          n_wdata.prev = NIL;
        end
        state_nxt = S_IDLE;
      end
      S_MG1: begin
        if (is_nil(q_rdata.head)) begin
          state_nxt = S_IDLE;
        end else begin
          hb_nxt    = q_rdata.head;
          tb_nxt    = q_rdata.tail;
          q_re      = 1'b1;
          q_raddr   = QRAM_W'(in_r.queue_a);
          state_nxt = S_MG2;
        end
      end
      S_MG2: begin
        h_nxt   = q_rdata.head;
        t_nxt   = q_rdata.tail;
        q_we    = 1'b1;
        q_waddr = QRAM_W'(in_r.queue_b);
        q_wdata = '{head: NIL, tail: NIL};
        if (in_r.at_back) begin
          hb_nxt    = tb_r;
          tb_nxt    = hb_r;
          nd_nxt    = hb_r;
          n_re      = 1'b1;
          n_raddr   = NODE_W'(hb_r);
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_LK0;
        end
      end
      S_WALK: begin
        n_we         = 1'b1;
        n_waddr      = NODE_W'(nd_r);
        n_wdata      = n_rdata;
        n_wdata.next = n_rdata.prev;
        n_wdata.prev = n_rdata.next;
        if (is_nil(n_rdata.next)) begin
          state_nxt = S_LK0;
        end else begin
          nd_nxt  = n_rdata.next;
          n_re    = 1'b1;
          n_raddr = NODE_W'(n_rdata.next);
        end
      end
      S_LK0: begin
        q_we = 1'b1;
        if (is_nil(t_r)) begin
          q_wdata   = '{head: hb_r, tail: tb_r};
          state_nxt = S_IDLE;
        end else begin
          q_wdata   = '{head: h_r, tail: tb_r};
          n_re      = 1'b1;
          n_raddr   = NODE_W'(t_r);
          state_nxt = S_LK1;
        end
      end
      S_LK1: begin
        n_we         = 1'b1;
        n_waddr      = NODE_W'(t_r);
        n_wdata      = n_rdata;
        n_wdata.next = hb_r;
        n_re         = 1'b1;
        n_raddr      = NODE_W'(hb_r);
        state_nxt    = S_LK2;
      end
      S_LK2: begin
        n_we         = 1'b1;
        n_waddr      = NODE_W'(hb_r);
        n_wdata      = n_rdata;
        n_wdata.prev = t_r;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_node_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    n_we && n_re |-> n_waddr != n_raddr)
    else $error("node RAM read and write hit the same entry");

  a_pop_answers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PO2 |=> out_valid_r && out_r.status == STS_POPPED)
    else $error("pop did not deliver its value");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !out_valid_r && busy)
    else $error("activity during clearing pass");

  a_free_head_moves: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PO2 |=> free_head_r == $past(nd_r))
    else $error("popped node not returned to the free list");

  a_walk_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> $past(state_r) == S_WALK || $past(state_r) == S_MG2)
    else $error("list walk entered out of sequence");

endmodule
